// File: sv/crcisc_pkg.sv
package crcisc_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned RSP_DATA_W  = 72;

   localparam logic [WORD_W-1:0] CRC_POLY   = 32'hEDB88320;
   localparam logic [WORD_W-1:0] WORD_ONES  = 32'hFFFFFFFF;

   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_SIZE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_CRC  = 1'd1;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              byte_valid;
      logic              last_item;
   } item_type;

   typedef struct packed {
      logic [WORD_W-1:0] crc_value;
      logic [WORD_W-1:0] byte_total;
      logic              size_match;
      logic              crc_match;
      logic              image_good;
      logic              set_good;
   } result_type;

   // reflected crc-32, one byte, bit by bit
   function automatic logic [WORD_W-1:0] crc_absorb_byte(input logic [WORD_W-1:0] crc,
                                                          input logic [BYTE_W-1:0] data);
      logic [WORD_W-1:0] c;
      c = crc ^ {{(WORD_W-BYTE_W){1'b0}}, data};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: sv/crcisc_accum.sv
module crcisc_accum import crcisc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  item_type          item,
   input  logic [WORD_W-1:0] expected_size,
   input  logic [WORD_W-1:0] expected_crc,
   output result_type        result
);

   logic [WORD_W-1:0] running_crc_ff, running_crc_in;
   logic [WORD_W-1:0] running_count_ff, running_count_in;
   logic              all_good_ff, all_good_in;

   logic [WORD_W-1:0] crc_upd;
   logic [WORD_W-1:0] count_upd;
   logic [WORD_W-1:0] final_crc;
   logic              size_ok;
   logic              crc_ok;
   logic              good;

   always_comb begin
      crc_upd   = item.byte_valid ? crc_absorb_byte(running_crc_ff, item.data_byte)
                                  : running_crc_ff;
      // count saturates at all ones
      count_upd = (item.byte_valid && (running_count_ff != WORD_ONES))
                  ? running_count_ff + WORD_W'(1) : running_count_ff;
      final_crc = crc_upd ^ WORD_ONES;
      size_ok   = (count_upd == expected_size);
      crc_ok    = (final_crc == expected_crc);
      good      = size_ok & crc_ok;

      result.crc_value  = final_crc;
      result.byte_total = count_upd;
      result.size_match = size_ok;
      result.crc_match  = crc_ok;
      result.image_good = good;
      result.set_good   = all_good_ff & good;
   end

   always_comb begin
      running_crc_in   = running_crc_ff;
      running_count_in = running_count_ff;
      all_good_in      = all_good_ff;
      if (step) begin
         if (item.last_item) begin
            running_crc_in   = WORD_ONES;
            running_count_in = '0;
            all_good_in      = all_good_ff & good;
         end else begin
            running_crc_in   = crc_upd;
            running_count_in = count_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_crc_ff   <= WORD_ONES;
         running_count_ff <= '0;
         all_good_ff      <= 1'b1;
      end else begin
         running_crc_ff   <= running_crc_in;
         running_count_ff <= running_count_in;
         all_good_ff      <= all_good_in;
      end
   end

endmodule

// File: sv/crc32_image_size_check_core.sv
// image size and crc-32 checker
//
// requests come in on the req_ stream, one image byte per request. req_tuser
// marks whether req_tdata carries a byte, req_tlast closes the image; a
// closing request may carry no byte, so empty images can be closed too.
// every closing request yields one response on the rsp_ stream with the
// final crc-32 (reflected, poly edb88320, preset and final xor all ones),
// the saturating byte count, size/crc/image match flags against the
// expected values in the csr_ registers, and a sticky all-good flag.
//
// a request lands in an input register; from there the byte-wide crc update
// and compares run in one pass into the output register that drives
// rsp_tvalid. one request per cycle is taken as long as the output register
// can drain.
// when rsp_tready is low the output register holds; a request still moves
// on if it does not close an image, otherwise req_tready drops until the
// response is taken.
// reset clears both stages, presets the running crc and count and sets the
// all-good flag; expected_size and expected_crc reset to zero.
module crc32_image_size_check_core import crcisc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [BYTE_W-1:0]      req_tdata,   // data_byte
   input  logic                   req_tuser,   // byte_valid
   input  logic                   req_tlast,   // last_item
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // crc_value, byte_total, size_match, crc_match, image_good, set_good, zero pad
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_wdata
);

   logic [WORD_W-1:0] expected_size_ff;
   logic [WORD_W-1:0] expected_crc_ff;

   logic       item_valid_ff, item_valid_in;
   item_type   item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_result_ff;
   result_type result;

   logic req_accept;
   logic out_free;
   logic item_adv;

   always_comb begin
      out_free      = !rsp_valid_ff || rsp_tready;
      item_adv      = item_valid_ff && (!item_ff.last_item || out_free);
      req_tready    = !item_valid_ff || item_adv;
      req_accept    = req_tvalid && req_tready;
      item_valid_in = req_accept ? 1'b1 : (item_adv ? 1'b0 : item_valid_ff);
      if (item_adv && item_ff.last_item) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   crcisc_accum u_accum (
      .clock         (clock),
      .reset         (reset),
      .step          (item_adv),
      .item          (item_ff),
      .expected_size (expected_size_ff),
      .expected_crc  (expected_crc_ff),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_size_ff <= '0;
         expected_crc_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_EXPECTED_SIZE: expected_size_ff <= csr_wdata;
            CSR_EXPECTED_CRC:  expected_crc_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.data_byte  <= req_tdata;
         item_ff.byte_valid <= req_tuser;
         item_ff.last_item  <= req_tlast;
      end
      if (item_adv && item_ff.last_item) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000,
                        rsp_result_ff.set_good,
                        rsp_result_ff.image_good,
                        rsp_result_ff.crc_match,
                        rsp_result_ff.size_match,
                        rsp_result_ff.byte_total,
                        rsp_result_ff.crc_value};

   a_reset_clears_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("response valid right after reset");

   a_good_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_result_ff.image_good ==
                        (rsp_result_ff.size_match && rsp_result_ff.crc_match)))
      else $error("image_good does not match size and crc flags");

   a_set_implies_image: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_result_ff.set_good) |-> rsp_result_ff.image_good)
      else $error("set_good high on a bad image");

   a_open_item_moves: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && !item_ff.last_item) |-> item_adv)
      else $error("non-closing request stuck in input register");

endmodule
